[design/text_glyph_renderer_5x8_defines.svh]
// Assertion macros used by the glyph renderer's raster module
`ifndef TEXT_GLYPH_RENDERER_5X8_DEFINES_SVH
`define TEXT_GLYPH_RENDERER_5X8_DEFINES_SVH
`ifndef SYNTHESIS
`define TGR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TGR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TGR_ASSERT_IMP(name, clk, rst, ante, cons)
`define TGR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[design/tgr_pkg.sv]
// Types, codes and glyph row decode for the 5x8 glyph renderer
package tgr_pkg;

  localparam int GLYPH_COLS = 5;

  localparam logic [1:0] KIND_FONT = 2'd0;
  localparam logic [1:0] KIND_TEXT = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic REG_SCREEN_WIDTH = 1'b0;
  localparam logic REG_Y_OFFSET     = 1'b1;

  localparam logic [9:0] SCREEN_WIDTH_RESET = 10'd160;

  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_ASCII_END = 8'd127;
  localparam logic [7:0] LEAD_D0      = 8'd208;
  localparam logic [7:0] LEAD_D1      = 8'd209;
  localparam logic [7:0] LEAD_C2      = 8'd194;
  localparam logic [7:0] TRAIL_IO_LC  = 8'd145;
  localparam logic [7:0] TRAIL_IO_UC  = 8'd129;
  localparam logic [7:0] TRAIL_DEG    = 8'd176;

  localparam logic signed [9:0] ROW_IO_LC   = 10'sd159;
  localparam logic signed [9:0] ROW_IO_UC   = 10'sd160;
  localparam logic signed [9:0] ROW_DEG     = 10'sd161;
  localparam logic signed [9:0] ASCII_BIAS  = 10'sd32;
  localparam logic signed [9:0] D0_BIAS     = 10'sd49;
  localparam logic signed [9:0] D1_BIAS     = 10'sd15;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  font_addr;
    logic [7:0]  font_data;
    logic [7:0]  text_byte;
    logic        first_byte;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
  } item_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [10:0] pixel_y;
    logic [15:0] pixel_color;
    logic        glyph_last;
  } pixel_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [10:0] y;
    logic [15:0] fg;
    logic [15:0] bg;
  } glyph_job_t;

  typedef struct packed {
    logic              skip;
    logic signed [9:0] row;
  } glyph_row_t;

  function automatic glyph_row_t glyph_row(input logic [7:0] lead, input logic [7:0] trail);
    glyph_row_t r;
    r.skip = 1'b0;
    r.row  = $signed({2'b00, lead}) - ASCII_BIAS;
    if (lead < CH_ASCII_END) begin
      r.row = $signed({2'b00, lead}) - ASCII_BIAS;
    end else if (lead == LEAD_D1 && trail == TRAIL_IO_LC) begin
      r.row = ROW_IO_LC;
    end else if (lead == LEAD_D0 && trail == TRAIL_IO_UC) begin
      r.row = ROW_IO_UC;
    end else if (lead == LEAD_C2 && trail == TRAIL_DEG) begin
      r.row = ROW_DEG;
    end else if (lead == LEAD_D0) begin
      r.row = $signed({2'b00, trail}) - D0_BIAS;
    end else if (lead == LEAD_D1) begin
      r.row = $signed({2'b00, trail}) + D1_BIAS;
    end else begin
      r.skip = 1'b1;
    end
    return r;
  endfunction

endpackage

[design/tgr_font_mem.sv]
// Font store: one write port, one registered read port
module tgr_font_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/tgr_raster.sv]
// Glyph rasterizer: fetches five font columns and emits forty pixels
`include "text_glyph_renderer_5x8_defines.svh"
module tgr_raster #(
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [AW-1:0]       base,
  input  tgr_pkg::glyph_job_t job,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output tgr_pkg::pixel_t     pixel
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } rast_state_t;

  rast_state_t state;
  logic [AW-1:0] ptr;
  logic [2:0]    col;
  logic [2:0]    bit_idx;
  logic [7:0]    col_byte;
  glyph_job_t    glyph;

  logic advance;
  logic emit;
  logic col_done;
  logic last_col;

  assign advance  = !pixel_valid || !pixel_stall;
  assign emit     = (state == ST_EMIT) && advance;
  assign col_done = emit && (bit_idx == 3'd7);
  assign last_col = (col == 3'(GLYPH_COLS - 1));
  assign busy     = (state != ST_IDLE);

  assign rd_en   = ((state == ST_IDLE) && start) || (state == ST_FETCH) ||
                   (col_done && (col < 3'(GLYPH_COLS - 2)));
  assign rd_addr = (state == ST_IDLE) ? base : ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pixel_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        ptr <= AW'(rd_addr + 1'b1);
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            glyph <= job;
            col   <= 3'd0;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          col_byte <= rd_data;
          bit_idx  <= 3'd0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            bit_idx <= 3'(bit_idx + 1'b1);
            if (col_done) begin
              col_byte <= rd_data;
              col      <= 3'(col + 1'b1);
              if (last_col) begin
                state <= ST_IDLE;
              end
            end else begin
              col_byte <= {col_byte[6:0], 1'b0};
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (emit) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel.pixel_x     <= 10'(glyph.x + {7'b0, col});
      pixel.pixel_y     <= 11'(glyph.y + {8'b0, ~bit_idx});
      pixel.pixel_color <= col_byte[7] ? glyph.fg : glyph.bg;
      pixel.glyph_last  <= last_col && (bit_idx == 3'd7);
    end
  end

  `TGR_ASSERT_IMP(a_start_when_idle, clk, rst, start, state == ST_IDLE)
  `TGR_ASSERT_NEXT(a_fetch_then_emit, clk, rst, state == ST_FETCH, state == ST_EMIT)
  `TGR_ASSERT_NEXT(a_last_pixel_ends, clk, rst, col_done && last_col, state == ST_IDLE && pixel_valid && pixel.glyph_last)

endmodule

[design/text_glyph_renderer_5x8.sv]
// Top level of the 5x8 glyph renderer: registers, string state and decode
//
// Text bytes (ASCII and two-byte UTF-8 Cyrillic, Io/io and the degree sign)
// are paired with the byte that follows; each drawable pair yields 40 pixel
// transactions, column 0..4 and bottom row to top row within a column, with
// glyph_last on the fortieth. An item that draws a glyph occupies the block
// for the accept cycle, the first column read from the synchronous font
// memory, then one pixel per cycle through the single output register
// (longer while the pixel channel stalls). Font writes, end items with
// nothing held and skipped codes leave the item channel free. The font
// memory has no clearing pass; read only glyphs that have been loaded.
module text_glyph_renderer_5x8 #(
  parameter int FONT_BYTES    = 1024,
  parameter int GLYPH_ADVANCE = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            item_valid,
  output logic            item_stall,
  input  tgr_pkg::item_t  item,
  output logic            pixel_valid,
  input  logic            pixel_stall,
  output tgr_pkg::pixel_t pixel
);
  import tgr_pkg::*;

  localparam int AW    = $clog2(FONT_BYTES);
  localparam int CMP_W = (AW > 11 ? AW : 11) + 2;

  logic [9:0]  screen_width;
  logic [7:0]  y_offset;
  logic [9:0]  cursor_x;
  logic [10:0] cursor_y;
  logic [15:0] fore_colour;
  logic [15:0] back_colour;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic        string_stopped;

  logic        busy;
  logic        accept;
  logic        cfg_write;
  logic        font_item;
  logic        text_item;
  logic        end_item;
  logic        restart;
  logic        addr_ok;
  logic [9:0]  cx;
  logic [10:0] cy;
  logic [15:0] fg;
  logic [15:0] bg;
  logic        hv;
  logic        st;
  logic [7:0]  trail;
  logic        draw_try;
  logic        fits;
  glyph_row_t  gr;
  logic        draw_go;
  logic        stop_set;
  logic [CMP_W-1:0] row5;
  logic        in_store;
  logic [AW-1:0] base;
  glyph_job_t  job;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;

  assign font_item = accept && (item.kind == KIND_FONT);
  assign text_item = accept && (item.kind == KIND_TEXT);
  assign end_item  = accept && ((item.kind == KIND_END) ||
                                ((item.kind == KIND_TEXT) && (item.text_byte == 8'd0)));
  assign restart   = text_item && item.first_byte;
  assign addr_ok   = CMP_W'(item.font_addr) < CMP_W'(FONT_BYTES);

  assign cx = restart ? item.start_x : cursor_x;
  assign cy = restart ? 11'({1'b0, item.start_y} + {3'b0, y_offset}) : cursor_y;
  assign fg = restart ? item.fg_color : fore_colour;
  assign bg = restart ? item.bg_color : back_colour;
  assign hv = restart ? 1'b0 : held_valid;
  assign st = restart ? 1'b0 : string_stopped;

  assign trail    = end_item ? 8'd0 : item.text_byte;
  assign draw_try = (text_item || end_item) && hv;
  assign fits     = ({1'b0, cx} + 11'(GLYPH_ADVANCE)) <= {1'b0, screen_width};
  assign gr       = glyph_row(held_byte, trail);
  assign draw_go  = draw_try && !st && fits && !gr.skip;
  assign stop_set = draw_try && !st && !fits;

  assign row5     = CMP_W'(gr.row[8:0]) * CMP_W'(GLYPH_COLS);
  assign in_store = (held_byte > CH_SPACE) && !gr.row[9] &&
                    ((row5 + CMP_W'(GLYPH_COLS)) <= CMP_W'(FONT_BYTES));
  assign base     = in_store ? row5[AW-1:0] : '0;
  assign job      = '{x: cx, y: cy, fg: fg, bg: bg};

  always_comb begin
    case (paddr[2])
      REG_SCREEN_WIDTH: prdata = {22'b0, screen_width};
      REG_Y_OFFSET:     prdata = {24'b0, y_offset};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= SCREEN_WIDTH_RESET;
      y_offset       <= 8'd0;
      cursor_x       <= 10'd0;
      cursor_y       <= 11'd0;
      fore_colour    <= 16'd0;
      back_colour    <= 16'd0;
      held_byte      <= 8'd0;
      held_valid     <= 1'b0;
      string_stopped <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          REG_SCREEN_WIDTH: screen_width <= pwdata[9:0];
          REG_Y_OFFSET:     y_offset     <= pwdata[7:0];
          default: ;
        endcase
      end
      if (text_item || end_item) begin
        cursor_x       <= draw_go ? 10'(cx + 10'(GLYPH_ADVANCE)) : cx;
        cursor_y       <= cy;
        fore_colour    <= fg;
        back_colour    <= bg;
        string_stopped <= st || stop_set;
        if (end_item) begin
          held_valid <= 1'b0;
          held_byte  <= 8'd0;
        end else begin
          held_valid <= 1'b1;
          held_byte  <= item.text_byte;
        end
      end
    end
  end

  tgr_font_mem #(
    .DEPTH (FONT_BYTES),
    .AW    (AW)
  ) u_font_mem (
    .clk     (clk),
    .wr_en   (font_item && addr_ok),
    .wr_addr (AW'(item.font_addr)),
    .wr_data (item.font_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tgr_raster #(
    .AW (AW)
  ) u_raster (
    .clk         (clk),
    .rst         (rst),
    .start       (draw_go),
    .base        (base),
    .job         (job),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule

[dv/tb_top.sv]
// Testbench for the 5x8 glyph renderer: directed and random strings, checked pixel by pixel
`timescale 1ns / 1ps
module tb_top;
  import tgr_pkg::*;

  localparam int FONT_BYTES    = 1024;
  localparam int GLYPH_ADVANCE = 6;
  localparam int GLYPH_ROWS    = 8;
  localparam int ROW_SKIP      = -1000;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [7:0] ASCII_LO       = 8'd33;
  localparam logic [7:0] ASCII_HI       = 8'd35;
  localparam logic [7:0] TRAIL_D0_DRAWN = 8'd144;
  localparam logic [7:0] TRAIL_D0_OUT   = 8'd255;
  localparam logic [7:0] TRAIL_D1_DRAWN = 8'd128;
  localparam logic [7:0] TRAIL_D1_OUT   = 8'd200;

  class pixel_scoreboard;
    logic [7:0]  font_mirror [FONT_BYTES];
    logic [9:0]  cur_x;
    logic [10:0] cur_y;
    logic [15:0] fore;
    logic [15:0] back;
    logic [7:0]  held;
    bit          held_ok;
    bit          stopped;
    logic [9:0]  width_reg;
    logic [7:0]  yoff_reg;
    pixel_t      expected_pixels [$];
    int          mismatches;

    function new();
      cur_x      = '0;
      cur_y      = '0;
      fore       = '0;
      back       = '0;
      held       = '0;
      held_ok    = 1'b0;
      stopped    = 1'b0;
      width_reg  = SCREEN_WIDTH_RESET;
      yoff_reg   = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_SCREEN_WIDTH) begin
        width_reg = val[9:0];
      end else begin
        yoff_reg = val[7:0];
      end
    endfunction

    function int font_row(logic [7:0] lead, logic [7:0] trail);
      if (lead < CH_ASCII_END) return int'(lead) - int'(ASCII_BIAS);
      if (lead == LEAD_D1 && trail == TRAIL_IO_LC) return int'(ROW_IO_LC);
      if (lead == LEAD_D0 && trail == TRAIL_IO_UC) return int'(ROW_IO_UC);
      if (lead == LEAD_C2 && trail == TRAIL_DEG) return int'(ROW_DEG);
      if (lead == LEAD_D0) return int'(trail) - int'(D0_BIAS);
      if (lead == LEAD_D1) return int'(trail) + int'(D1_BIAS);
      return ROW_SKIP;
    endfunction

    function void draw_glyph(logic [7:0] lead, logic [7:0] trail);
      int         row;
      int         base;
      int         c;
      int         b;
      logic [7:0] bits;
      pixel_t     px;
      if (stopped) return;
      if (int'(cur_x) + GLYPH_ADVANCE > int'(width_reg)) begin
        stopped = 1'b1;
        return;
      end
      row = font_row(lead, trail);
      if (row == ROW_SKIP) return;
      base = 0;
      if (lead > CH_SPACE && row >= 0 && row * GLYPH_COLS + GLYPH_COLS <= FONT_BYTES) begin
        base = row * GLYPH_COLS;
      end
      for (c = 0; c < GLYPH_COLS; c++) begin
        bits = font_mirror[base + c];
        for (b = 0; b < GLYPH_ROWS; b++) begin
          px.pixel_x     = cur_x + 10'(c);
          px.pixel_y     = cur_y + 11'(7 - b);
          px.pixel_color = bits[7 - b] ? fore : back;
          px.glyph_last  = (c == GLYPH_COLS - 1) && (b == GLYPH_ROWS - 1);
          expected_pixels.push_back(px);
        end
      end
      cur_x = cur_x + 10'(GLYPH_ADVANCE);
    endfunction

    function void finish_string();
      if (held_ok) draw_glyph(held, 8'd0);
      held_ok = 1'b0;
      held    = '0;
    endfunction

    function void note_item(item_t it);
      case (it.kind)
        KIND_FONT: begin
          if (int'(it.font_addr) < FONT_BYTES) font_mirror[it.font_addr] = it.font_data;
        end
        KIND_END: begin
          finish_string();
        end
        KIND_TEXT: begin
          if (it.first_byte) begin
            cur_x   = it.start_x;
            cur_y   = {1'b0, it.start_y} + {3'b000, yoff_reg};
            fore    = it.fg_color;
            back    = it.bg_color;
            held_ok = 1'b0;
            held    = '0;
            stopped = 1'b0;
          end
          if (it.text_byte == 8'd0) begin
            finish_string();
          end else begin
            if (held_ok) draw_glyph(held, it.text_byte);
            held    = it.text_byte;
            held_ok = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected pixel: x=%0d y=%0d color=%h last=%b",
                   got.pixel_x, got.pixel_y, got.pixel_color, got.glyph_last);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.pixel_color !== want.pixel_color || got.glyph_last !== want.glyph_last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("pixel mismatch: want x=%0d y=%0d c=%h l=%b got x=%0d y=%0d c=%h l=%b",
                   want.pixel_x, want.pixel_y, want.pixel_color, want.glyph_last,
                   got.pixel_x, got.pixel_y, got.pixel_color, got.glyph_last);
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst         = 1'b1;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid  = 1'b0;
  logic        item_stall;
  item_t       item        = '0;
  logic        pixel_valid;
  logic        pixel_stall = 1'b0;
  pixel_t      pixel;

  pixel_scoreboard sb = new();
  int          idle_pct  = 27;
  int          sent      = 0;
  int          cycles    = 0;
  logic [9:0]  width_now = SCREEN_WIDTH_RESET;

  text_glyph_renderer_5x8 #(
    .FONT_BYTES(FONT_BYTES),
    .GLYPH_ADVANCE(GLYPH_ADVANCE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (pixel_valid && !pixel_stall) sb.check_pixel(pixel);
    pixel_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic item_t make_item(logic [1:0] kind);
    item_t it;
    it.kind       = kind;
    it.font_addr  = 10'($urandom_range(1023));
    it.font_data  = 8'($urandom_range(255));
    it.text_byte  = 8'($urandom_range(1, 255));
    it.first_byte = (kind == KIND_TEXT) ? 1'b0 : 1'($urandom_range(1));
    it.start_x    = 10'($urandom_range(1023));
    it.start_y    = 10'($urandom_range(1023));
    it.fg_color   = 16'($urandom_range(65535));
    it.bg_color   = 16'($urandom_range(65535));
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    sent++;
  endtask

  task automatic put_text(input logic [7:0] b);
    item_t it;
    it = make_item(KIND_TEXT);
    it.text_byte = b;
    send_item(it);
  endtask

  task automatic put_kind(input logic [1:0] kind);
    send_item(make_item(kind));
  endtask

  task automatic open_string(input logic [7:0] b, input logic [9:0] x, input logic [9:0] y,
                             input logic [15:0] fg, input logic [15:0] bg);
    item_t it;
    it = make_item(KIND_TEXT);
    it.text_byte  = b;
    it.first_byte = 1'b1;
    it.start_x    = x;
    it.start_y    = y;
    it.fg_color   = fg;
    it.bg_color   = bg;
    send_item(it);
  endtask

  task automatic write_font(input int addr);
    item_t it;
    it = make_item(KIND_FONT);
    it.font_addr = 10'(addr);
    send_item(it);
  endtask

  task automatic write_row(input int row);
    for (int c = 0; c < GLYPH_COLS; c++) write_font(row * GLYPH_COLS + c);
  endtask

  task automatic wait_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == REG_SCREEN_WIDTH) width_now = val[9:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [9:0] w, input logic [7:0] yo);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SCREEN_WIDTH, {22'd0, w});
    write_reg(REG_Y_OFFSET, {24'd0, yo});
  endtask

  task automatic put_random_symbol();
    case ($urandom_range(9))
      0, 1, 2, 3: put_text(8'($urandom_range(int'(ASCII_LO), int'(ASCII_HI))));
      4: begin
        put_text(LEAD_D0);
        put_text(($urandom_range(1) == 0) ? TRAIL_D0_DRAWN : TRAIL_D0_OUT);
      end
      5: begin
        put_text(LEAD_D1);
        put_text(($urandom_range(1) == 0) ? TRAIL_D1_DRAWN : TRAIL_D1_OUT);
      end
      6: begin
        case ($urandom_range(2))
          0: begin
            put_text(LEAD_D1);
            put_text(TRAIL_IO_LC);
          end
          1: begin
            put_text(LEAD_D0);
            put_text(TRAIL_IO_UC);
          end
          default: begin
            put_text(LEAD_C2);
            put_text(TRAIL_DEG);
          end
        endcase
      end
      7: put_text(8'($urandom_range(1, int'(CH_SPACE))));
      8: put_text(8'($urandom_range(int'(CH_ASCII_END), int'(LEAD_C2))));
      default: put_text(8'($urandom_range(210, 255)));
    endcase
  endtask

  task automatic random_string();
    logic [9:0] x;
    int         len;
    x   = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                   : 10'($urandom_range(int'(width_now)));
    len = $urandom_range(2, 8);
    open_string(8'($urandom_range(int'(CH_SPACE), int'(ASCII_HI))), x,
                10'($urandom_range(1023)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)));
    repeat (len) put_random_symbol();
    case ($urandom_range(7))
      0: put_kind(KIND_UNUSED);
      1: put_kind(KIND_FONT);
      default: ;
    endcase
    case ($urandom_range(3))
      0, 1: put_kind(KIND_END);
      2: put_text(8'd0);
      default: ;
    endcase
  endtask

  task automatic random_phase(input int count);
    sent = 0;
    while (sent < count) random_string();
  endtask

  initial begin
    item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r <= int'(ASCII_HI) - int'(ASCII_BIAS); r++) write_row(r);
    write_row(int'(TRAIL_D0_DRAWN) - int'(D0_BIAS));
    write_row(int'(TRAIL_D1_DRAWN) + int'(D1_BIAS));
    write_row(int'(ROW_IO_LC));
    write_row(int'(ROW_IO_UC));
    write_row(int'(ROW_DEG));

    open_string(CH_SPACE, 10'd0, 10'd0, 16'hFFFF, 16'h0000);
    put_text(8'd33);
    put_text(8'd35);
    put_text(LEAD_D0);
    put_text(TRAIL_IO_UC);
    put_text(LEAD_D1);
    put_text(TRAIL_IO_LC);
    put_text(LEAD_C2);
    put_text(TRAIL_DEG);
    put_text(LEAD_D0);
    put_text(8'd255);
    put_text(LEAD_D1);
    put_text(8'd128);
    put_text(CH_ASCII_END);
    put_text(8'd1);
    put_text(LEAD_D0);
    put_text(8'd1);
    put_kind(KIND_END);
    put_kind(KIND_END);
    put_text(8'd34);
    put_text(8'd0);
    put_kind(KIND_UNUSED);
    it = make_item(KIND_END);
    it.first_byte = 1'b1;
    send_item(it);
    open_string(8'd33, 10'd150, 10'd1023, 16'h0000, 16'hFFFF);
    put_text(8'd34);
    put_text(8'd35);
    put_text(8'd33);
    put_kind(KIND_END);

    set_config(10'd1023, 8'd255);
    open_string(8'd34, 10'd1017, 10'd1023, 16'hFFFF, 16'h0000);
    put_text(8'd35);
    put_text(8'd33);
    put_kind(KIND_END);
    random_phase(6);

    set_config(10'd1, 8'($urandom_range(255)));
    random_phase(4);

    idle_pct = 0;
    set_config(SCREEN_WIDTH_RESET, 8'd0);
    random_phase(5);
    wait_results();
    random_phase(5);
    idle_pct = 27;

    set_config(10'($urandom_range(1, 1023)), 8'($urandom_range(255)));
    random_phase(6);

    set_config(10'd96, 8'd40);
    random_phase(6);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[text_glyph_renderer_5x8.f]
+incdir+design
design/tgr_pkg.sv
design/tgr_font_mem.sv
design/tgr_raster.sv
design/text_glyph_renderer_5x8.sv
dv/tb_top.sv
